@@ hw/rtl/lsfe_pkg.sv @@
`default_nettype none
package lsfe_pkg;
  localparam int unsigned MaxOut    = 7905;
  localparam int unsigned MaxLights = 512;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } lsfe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } lsfe_out_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [15:0] divisor;
  } lsfe_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [47:0] quotient;
  } lsfe_div_rsp_t;
endpackage
`default_nettype wire

@@ hw/rtl/led_strip_frame_encoder.sv @@
`default_nettype none
// Encodes one RGB pixel per request into the strip's serial byte stream. Each
// channel on the cubic part of the ramp needs the setup states S_CHAN and S_MUL1
// and three divisions on one shared bit-serial divider, a zero or linear channel
// passes straight through S_CHAN, then the brightness scale is picked and applied,
// and each byte is emitted once the output register is free. Input stall is high
// from the accepted request until its last byte has entered the output register.
module led_strip_frame_encoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lsfe_pkg::lsfe_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lsfe_pkg::lsfe_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_data
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CHAN  = 8'b00000010,
    S_MUL1  = 8'b00000100,
    S_DIV1  = 8'b00001000,
    S_DIV2  = 8'b00010000,
    S_DIV3  = 8'b00100000,
    S_SCALE = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  state_t        st_r, st_nxt;
  logic [15:0]   maxi_r;
  logic [9:0]    cnt_r, cnt_nxt;
  lsfe_pkg::lsfe_in_t pix_r;
  logic [1:0]    ch_r, ch_nxt;
  logic [12:0]   lv_r [3];
  logic [7:0]    ob_r [3];
  logic [47:0]   t_r, t_nxt;
  logic [1:0]    sc_r;
  logic [2:0]    bidx_r, bidx_nxt;
  logic [6:0]    brem_r, brem_nxt;
  logic          start_r, start_nxt;
  logic          out_v_r, out_v_nxt;
  lsfe_pkg::lsfe_out_t out_r, out_nxt;
  lsfe_pkg::lsfe_div_req_t dreq;
  lsfe_pkg::lsfe_div_rsp_t drsp;

  logic [12:0] full;
  logic [6:0]  cut;
  logic [7:0]  in_rng, half;
  logic [12:0] out_rng;
  logic [7:0]  v;
  logic [7:0]  x;
  logic [47:0] div_q;
  logic [12:0] mx;
  logic [7:0]  hd;
  logic [26:0] q31 [3];
  logic [6:0]  tail_n;
  logic        wr;

  assign full = (maxi_r == 16'd0 || maxi_r > 16'(lsfe_pkg::MaxOut)) ?
                13'(lsfe_pkg::MaxOut) : (maxi_r < 16'd255 ? 13'd255 : maxi_r[12:0]);
  assign cut     = 7'((({13'd0, full} + 26'd50) * 26'd5243) >> 19);
  assign in_rng  = 8'd255 - {1'b0, cut};
  assign half    = {1'b0, in_rng[7:1]};
  assign out_rng = full - {6'd0, cut};
  assign v = (ch_r == 2'd0) ? pix_r.red : (ch_r == 2'd1 ? pix_r.green : pix_r.blue);
  assign x = v - {1'b0, cut};
  assign div_q = drsp.quotient;
  assign mx = (lv_r[0] > lv_r[1]) ? (lv_r[0] > lv_r[2] ? lv_r[0] : lv_r[2])
                                  : (lv_r[1] > lv_r[2] ? lv_r[1] : lv_r[2]);
  assign hd = (sc_r == 2'd0) ? 8'hE1 : (sc_r == 2'd1 ? 8'hE2 :
              (sc_r == 2'd2 ? 8'hE4 : 8'hFF));
  assign tail_n = 7'(({1'b0, cnt_r} + ((cnt_r < 10'(lsfe_pkg::MaxLights)) ? 11'd1 : 11'd0))
                  >> 4) + 7'd1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q31[i] = ({13'd0, {1'b0, lv_r[i]} + 14'd15} * 27'd8457) >> 18;
    end
  end

  assign dreq.start    = start_r;
  assign dreq.dividend = t_r;
  assign dreq.divisor  = {8'd0, in_rng};

  lsfe_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign wr = !out_v_r || !out_stall;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    ch_nxt    = ch_r;
    t_nxt     = t_r;
    bidx_nxt  = bidx_r;
    brem_nxt  = brem_r;
    start_nxt = 1'b0;
    out_v_nxt = out_v_r && out_stall;
    out_nxt   = out_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt = S_CHAN;
          ch_nxt = 2'd0;
        end
      end
      S_CHAN: begin
        if (ch_r == 2'd3) begin
          st_nxt = S_SCALE;
          ch_nxt = 2'd0;
        end else if (v == 8'd0 || v < {1'b0, cut}) begin
          ch_nxt = ch_r + 2'd1;
        end else begin
          t_nxt  = {32'd0, {8'd0, x} * {8'd0, x}};
          st_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        t_nxt     = {24'd0, {8'd0, t_r[15:0]} * {16'd0, x}} + {40'd0, half};
        start_nxt = 1'b1;
        st_nxt    = S_DIV1;
      end
      S_DIV1: begin
        if (drsp.done) begin
          t_nxt     = {19'd0, {13'd0, div_q[15:0]} * {16'd0, out_rng}} +
                      {32'd0, {8'd0, half} * {8'd0, half}};
          start_nxt = 1'b1;
          st_nxt    = S_DIV2;
        end
      end
      S_DIV2: begin
        if (drsp.done) begin
          t_nxt     = div_q;
          start_nxt = 1'b1;
          st_nxt    = S_DIV3;
        end
      end
      S_DIV3: begin
        if (drsp.done) begin
          ch_nxt = ch_r + 2'd1;
          st_nxt = S_CHAN;
        end
      end
      S_SCALE: begin
        st_nxt   = S_EMIT;
        bidx_nxt = (cnt_r == 10'd0) ? 3'd0 : 3'd4;
        brem_nxt = 7'd0;
      end
      S_EMIT: begin
        if (wr) begin
          out_v_nxt = 1'b1;
          out_nxt.run_last = 1'b0;
          if (bidx_r < 3'd4) begin
            out_nxt.out_byte = 8'h00;
            bidx_nxt = bidx_r + 3'd1;
          end else if (bidx_r == 3'd4) begin
            out_nxt.out_byte = hd;
            bidx_nxt = 3'd5;
          end else if (bidx_r != 3'd7 || !pix_r.last_pixel) begin
            out_nxt.out_byte = ob_r[2'(3'd7 - bidx_r)];
            if (bidx_r == 3'd7) begin
              out_nxt.run_last = 1'b1;
              st_nxt  = S_IDLE;
              cnt_nxt = (cnt_r < 10'(lsfe_pkg::MaxLights)) ? cnt_r + 10'd1 : cnt_r;
            end else begin
              bidx_nxt = bidx_r + 3'd1;
            end
            if (bidx_r == 3'd7 && pix_r.last_pixel) out_nxt.run_last = 1'b0;
          end
          if (bidx_r == 3'd7 && pix_r.last_pixel) begin
            if (brem_r == 7'd0) begin
              out_nxt.out_byte = ob_r[0];
              bidx_nxt = 3'd6;
              brem_nxt = 7'd127;
            end else if (brem_r == 7'd127) begin
              out_v_nxt = out_v_r && out_stall;
            end else begin
              out_nxt.out_byte = 8'hFF;
              brem_nxt = brem_r - 7'd1;
              if (brem_r == 7'd1) begin
                out_nxt.run_last = 1'b1;
                st_nxt  = S_IDLE;
                cnt_nxt = '0;
              end
            end
          end
          if (bidx_r == 3'd6 && brem_r == 7'd127) begin
            out_nxt.out_byte = 8'hFF;
            bidx_nxt = 3'd7;
            brem_nxt = tail_n - 7'd1;
            if (tail_n == 7'd1) begin
              out_nxt.run_last = 1'b1;
              st_nxt  = S_IDLE;
              cnt_nxt = '0;
            end
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      maxi_r  <= '0;
      cnt_r   <= '0;
      start_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      start_r <= start_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) maxi_r <= cfg_data;
    end
    ch_r   <= ch_nxt;
    t_r    <= t_nxt;
    bidx_r <= bidx_nxt;
    brem_r <= brem_nxt;
    out_r  <= out_nxt;
    if (st_r == S_IDLE && in_valid) pix_r <= in_data;
    if (st_r == S_CHAN && ch_r != 2'd3) lv_r[ch_r] <= {5'd0, v};
    if (st_r == S_DIV3 && drsp.done) lv_r[ch_r] <= div_q[12:0] + {6'd0, cut};
    if (st_r == S_CHAN && ch_r == 2'd3) begin
      sc_r <= (mx <= 13'd255) ? 2'd0 : (mx <= 13'd511 ? 2'd1 : (mx <= 13'd1023 ? 2'd2 : 2'd3));
    end
    if (st_r == S_SCALE) begin
      for (int i = 0; i < 3; i++) begin
        ob_r[i] <= (sc_r == 2'd0) ? lv_r[i][7:0] : (sc_r == 2'd1 ? lv_r[i][8:1] :
                   (sc_r == 2'd2 ?
                    ((lv_r[i] + 13'd2) > 13'd1023 ? 8'd255 : 8'(lv_r[i] + 13'd2 >> 2)) :
                    (q31[i] > 27'd255 ? 8'd255 : q31[i][7:0])));
      end
    end
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 10'(lsfe_pkg::MaxLights)) else $error("pixel count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

@@ hw/rtl/lsfe_div.sv @@
`default_nettype none
module lsfe_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lsfe_pkg::lsfe_div_req_t req,
  output lsfe_pkg::lsfe_div_rsp_t     rsp
);
  // Restoring divider, one quotient bit per cycle.
  logic [47:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0] trial;
  logic [16:0] sub;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], quo_r[47]};
    sub      = trial - {1'b0, den_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      cnt_nxt  = 6'd47;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!sub[16]) begin
        rem_nxt = sub;
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

@@ dv/led_strip_frame_encoder_test.sv @@
`timescale 1ns / 1ps
module led_strip_frame_encoder_test;
  localparam int unsigned NumRandom = 260;
  localparam int unsigned TailIdle  = 800;

  typedef struct {
    lsfe_pkg::lsfe_in_t px;
    logic        has_bytes;
    logic [7:0]  head;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
  } pixel_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  lsfe_pkg::lsfe_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lsfe_pkg::lsfe_out_t out_data;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  led_strip_frame_encoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lsfe_pkg::lsfe_out_t byte_queue[$];
  logic [7:0]  typed_queue[$];
  logic        typed_valid[$];
  logic [15:0] model_full_reg = '0;
  logic [9:0]  model_count = '0;
  int unsigned errors = 0;
  int unsigned bytes_seen = 0;
  int unsigned pixels_sent = 0;
  logic        calm = 1'b0;
  logic        hold_off = 1'b0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %0s: got %0h want %0h (byte %0d)", what, got, want, bytes_seen);
  endtask

  function automatic logic [31:0] ramp(input logic [7:0] v);
    logic [31:0] full, cut, in_rng, out_rng, half, x, y;
    logic [63:0] t;
    if (v == 0) return 0;
    full = model_full_reg;
    if (full == 0 || full > lsfe_pkg::MaxOut) full = lsfe_pkg::MaxOut;
    else if (full < 255) full = 255;
    cut = (full + 50) / 100;
    if (v < cut) return v;
    x = v - cut;
    in_rng = 255 - cut;
    out_rng = full - cut;
    half = in_rng >> 1;
    t = 64'(x) * x * x + half;
    y = 32'(t / in_rng);
    t = (64'(y) * out_rng + 64'(half) * half) / in_rng / in_rng;
    return 32'(t) + cut;
  endfunction

  function automatic logic [7:0] sat(input logic [31:0] v);
    return v > 255 ? 8'hFF : v[7:0];
  endfunction

  task automatic predict_pixel(input lsfe_pkg::lsfe_in_t px);
    logic [31:0] r, g, b, tail;
    logic [7:0] head, ob, og, orr;
    r = ramp(px.red);
    g = ramp(px.green);
    b = ramp(px.blue);
    if (model_count == 0)
      repeat (4) byte_queue.push_back('{8'h00, 1'b0});
    if (r <= 255 && g <= 255 && b <= 255) begin
      head = 8'hE1; ob = b[7:0]; og = g[7:0]; orr = r[7:0];
    end else if (r <= 511 && g <= 511 && b <= 511) begin
      head = 8'hE2; ob = 8'(b >> 1); og = 8'(g >> 1); orr = 8'(r >> 1);
    end else if (r <= 1023 && g <= 1023 && b <= 1023) begin
      head = 8'hE4;
      ob = sat((b + 2) >> 2); og = sat((g + 2) >> 2); orr = sat((r + 2) >> 2);
    end else begin
      head = 8'hFF;
      ob = sat((b + 15) / 31); og = sat((g + 15) / 31); orr = sat((r + 15) / 31);
    end
    byte_queue.push_back('{head, 1'b0});
    byte_queue.push_back('{ob, 1'b0});
    byte_queue.push_back('{og, 1'b0});
    byte_queue.push_back('{orr, 1'b0});
    if (model_count < lsfe_pkg::MaxLights) model_count++;
    if (px.last_pixel) begin
      tail = model_count / 16 + 1;
      repeat (tail) byte_queue.push_back('{8'hFF, 1'b0});
      model_count = 0;
    end
    byte_queue[$].run_last = 1'b1;
  endtask

  task automatic send_pixel(input lsfe_pkg::lsfe_in_t px);
    if (!calm && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 15)) @(negedge clk);
    in_data = px;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(px);
    pixels_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (byte_queue.size() != 0) @(negedge clk);
    repeat (TailIdle) @(negedge clk);
  endtask

  task automatic write_full(input logic [15:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_full_reg = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (byte_queue.size() == 0) begin
        report("unexpected byte", out_data.out_byte, 0);
      end else begin
        if (typed_queue.size() != 0) begin
          if (typed_valid.pop_front() && out_data.out_byte != typed_queue[0])
            report("table byte", out_data.out_byte, typed_queue[0]);
          void'(typed_queue.pop_front());
        end
        if (out_data.out_byte != byte_queue[0].out_byte)
          report("out_byte", out_data.out_byte, byte_queue[0].out_byte);
        if (out_data.run_last != byte_queue[0].run_last)
          report("run_last", out_data.run_last, byte_queue[0].run_last);
        void'(byte_queue.pop_front());
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #400ms;
    $display("led_strip_frame_encoder_test: errors");
    $finish;
  end

  pixel_row_t table_rows[$];
  logic [15:0] settings[6] = '{16'd0, 16'd1, 16'd255, 16'd1000, 16'd7905, 16'd65535};

  initial begin
    lsfe_pkg::lsfe_in_t px;
    table_rows = '{
      '{'{8'd0, 8'd0, 8'd0, 1'b1}, 1'b1, 8'hE1, 8'd0, 8'd0, 8'd0},
      '{'{8'd1, 8'd1, 8'd1, 1'b0}, 1'b0, 8'h00, 8'd0, 8'd0, 8'd0},
      '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, 8'hFF, 8'd255, 8'd255, 8'd255},
      '{'{8'd128, 8'd64, 8'd200, 1'b0}, 1'b0, 8'h00, 8'd0, 8'd0, 8'd0},
      '{'{8'd79, 8'd80, 8'd81, 1'b0}, 1'b0, 8'h00, 8'd0, 8'd0, 8'd0},
      '{'{8'd255, 8'd0, 8'd0, 1'b0}, 1'b0, 8'h00, 8'd0, 8'd0, 8'd0},
      '{'{8'd0, 8'd0, 8'd255, 1'b1}, 1'b0, 8'h00, 8'd0, 8'd0, 8'd0},
      '{'{8'd170, 8'd85, 8'd42, 1'b1}, 1'b0, 8'h00, 8'd0, 8'd0, 8'd0}
    };
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (table_rows[i]) begin
      drain();
      if (model_count == 0) repeat (4) begin
        typed_queue.push_back(8'h00); typed_valid.push_back(1'b1);
      end
      typed_queue.push_back(table_rows[i].head); typed_valid.push_back(table_rows[i].has_bytes);
      typed_queue.push_back(table_rows[i].b0); typed_valid.push_back(table_rows[i].has_bytes);
      typed_queue.push_back(table_rows[i].b1); typed_valid.push_back(table_rows[i].has_bytes);
      typed_queue.push_back(table_rows[i].b2); typed_valid.push_back(table_rows[i].has_bytes);
      send_pixel(table_rows[i].px);
      drain();
      typed_queue.delete();
      typed_valid.delete();
    end
    foreach (settings[s]) begin
      write_full(settings[s]);
      for (int k = 0; k < 8; k++) begin
        px = '{8'(k * 37), 8'(k * 91), 8'(255 - k * 5), k == 7};
        send_pixel(px);
      end
    end
    write_full(16'd4000);
    hold_off = 1'b1;
    fork
      begin
        repeat (1500) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 4; k++) send_pixel('{8'($urandom), 8'($urandom), 8'($urandom), 1'b0});
    join
    drain();
    for (int k = 0; k < NumRandom; k++) begin
      if (k % 60 == 0)
        write_full($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(200, 8000)));
      if (k > NumRandom - 30) calm = 1'b1;
      px.red = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'd255 : 8'd0) : 8'($urandom);
      px.green = 8'($urandom);
      px.blue = $urandom_range(0, 4) == 0 ? 8'd255 : 8'($urandom);
      px.last_pixel = ($urandom_range(0, 7) == 0) || k == NumRandom - 1;
      send_pixel(px);
    end
    drain();
    $display("covered %0d pixels and %0d bytes over several full-scale settings,",
             pixels_sent, bytes_seen);
    $display("including random frame lengths and a long output hold-off");
    if (errors == 0) begin
      $display("led_strip_frame_encoder_test: clean");
    end else begin
      $display("led_strip_frame_encoder_test: errors");
    end
    $finish;
  end
endmodule
